### design/rdf_pkg.sv
// ----------------------------------------------------------------------------
// rdf_pkg
// Shared types, codes and tables for the radix digit formatter.
// ----------------------------------------------------------------------------
package rdf_pkg;

    localparam int VALUE_W = 32;
    localparam int DEC_DIGITS = 10;
    localparam int POS_W = 5;
    localparam int CNT_W = 6;
    localparam int WIDE_W = 38;

    typedef enum logic [1:0] {
        RADIX_BIN = 2'd0,
        RADIX_OCT = 2'd1,
        RADIX_DEC = 2'd2,
        RADIX_HEX = 2'd3
    } t_radix;

    typedef enum logic [1:0] {
        SIZE_BYTE = 2'd0,
        SIZE_WORD = 2'd1,
        SIZE_LONG = 2'd2,
        SIZE_ALT_LONG = 2'd3
    } t_size;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [VALUE_W-1:0] rem;
        logic [DEC_DIGITS-1:0][3:0] digits;
        t_radix radix;
        logic [CNT_W-1:0] ndig;
        logic pad;
    } t_item;

    // Digit count per radix and size.
    function automatic logic [CNT_W-1:0] digit_count(t_radix rc, t_size sz);
        logic [CNT_W-1:0] n;
        n = '0;
        case (rc)
            RADIX_BIN: begin
                case (sz)
                    SIZE_BYTE: n = CNT_W'(8);
                    SIZE_WORD: n = CNT_W'(16);
                    default:   n = CNT_W'(32);
                endcase
            end
            RADIX_OCT: begin
                case (sz)
                    SIZE_BYTE: n = CNT_W'(3);
                    SIZE_WORD: n = CNT_W'(6);
                    default:   n = CNT_W'(11);
                endcase
            end
            RADIX_DEC: begin
                case (sz)
                    SIZE_BYTE: n = CNT_W'(3);
                    SIZE_WORD: n = CNT_W'(5);
                    default:   n = CNT_W'(10);
                endcase
            end
            default: begin
                case (sz)
                    SIZE_BYTE: n = CNT_W'(2);
                    SIZE_WORD: n = CNT_W'(4);
                    default:   n = CNT_W'(8);
                endcase
            end
        endcase
        return n;
    endfunction

    function automatic logic [WIDE_W-1:0] pow10(int e);
        logic [WIDE_W-1:0] p;
        p = WIDE_W'(1);
        for (int i = 0; i < e; i++) begin
            p = WIDE_W'(p * WIDE_W'(10));
        end
        return p;
    endfunction

    function automatic logic [6:0] to_ascii(logic [3:0] d);
        logic [6:0] c;
        if (d < 4'd10) begin
            c = 7'(d) + 7'd48;
        end else begin
            c = 7'(d) + 7'd55;
        end
        return c;
    endfunction

endpackage

### design/radix_digit_formatter_top.sv
// ----------------------------------------------------------------------------
// radix_digit_formatter_top
// Unsigned value to ASCII digits in binary, octal, decimal or hex, MSB first.
// ----------------------------------------------------------------------------
// channel  dir  tdata                      tuser                      tlast
// s        in   [31:0] value               [1:0] size [3:2] radix     -
//                                          [4] pad_zeros
// m        out  [6:0] ascii_char, [7] 0    -                          last_char
//
// Input stage, ten decimal digit stages and the serializer form a pipeline;
// a request passes the input, stage and serializer item registers before its
// first character is registered for output. The serializer visits every digit
// position (suppressed ones too) before it takes the next number.
// Reset clears all valid bits and the serializer's control state; data registers are not reset.
// Stalls on the output hold the character register and back up the pipeline.
// ----------------------------------------------------------------------------
module radix_digit_formatter_top import rdf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] value
    input  logic [4:0]  i_s_tuser,   // [1:0] size_code, [3:2] radix_code, [4] pad_zeros
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [6:0] ascii_char, [7] zero
    output logic        o_m_tlast    // last_char
);

    logic  [DEC_DIGITS:0] valid_c;
    logic  [DEC_DIGITS:0] ready_c;
    t_item                item_c [DEC_DIGITS+1];
    logic  [6:0]          ochar;

    rdf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .i_value    (i_s_tdata),
        .i_size     (t_size'(i_s_tuser[1:0])),
        .i_radix    (t_radix'(i_s_tuser[3:2])),
        .i_pad      (i_s_tuser[4]),
        .o_ready    (o_s_tready),
        .o_valid    (valid_c[0]),
        .o_item     (item_c[0]),
        .i_ready_dn (ready_c[0])
    );

    // Stage j resolves decimal digit DEC_DIGITS-1-j.
    for (genvar j = 0; j < DEC_DIGITS; j++) begin : g_dec
        rdf_dec_stage #(.K(DEC_DIGITS - 1 - j)) u_stage (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_valid    (valid_c[j]),
            .i_item     (item_c[j]),
            .o_ready    (ready_c[j]),
            .o_valid    (valid_c[j+1]),
            .o_item     (item_c[j+1]),
            .i_ready_dn (ready_c[j+1])
        );
    end

    rdf_serializer u_ser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (valid_c[DEC_DIGITS]),
        .i_item     (item_c[DEC_DIGITS]),
        .o_ready    (ready_c[DEC_DIGITS]),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_char     (ochar),
        .o_m_tlast  (o_m_tlast)
    );

    assign o_m_tdata = {1'b0, ochar};

endmodule

### design/rdf_front.sv
// ----------------------------------------------------------------------------
// rdf_front
// Input stage: masks the value to its size and looks up the digit count.
// ----------------------------------------------------------------------------
module rdf_front import rdf_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [VALUE_W-1:0]  i_value,
    input  t_size               i_size,
    input  t_radix              i_radix,
    input  logic                i_pad,
    output logic                o_ready,
    output logic                o_valid,
    output t_item               o_item,
    input  logic                i_ready_dn
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    assign o_ready = !r_valid || i_ready_dn;

    always_comb begin
        n_item = '0;
        case (i_size)
            SIZE_BYTE: n_item.value = {24'd0, i_value[7:0]};
            SIZE_WORD: n_item.value = {16'd0, i_value[15:0]};
            default:   n_item.value = i_value;
        endcase
        n_item.rem   = n_item.value;
        n_item.radix = i_radix;
        n_item.ndig  = digit_count(i_radix, i_size);
        n_item.pad   = i_pad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### design/rdf_dec_stage.sv
// ----------------------------------------------------------------------------
// rdf_dec_stage
// One decimal digit per stage: compares the remainder against the nine
// multiples of its power of ten and subtracts the largest that fits.
// ----------------------------------------------------------------------------
module rdf_dec_stage import rdf_pkg::*; #(
    parameter int K = 0
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_item  i_item,
    output logic   o_ready,
    output logic   o_valid,
    output t_item  o_item,
    input  logic   i_ready_dn
);

    localparam logic [WIDE_W-1:0] P = pow10(K);

    logic              r_valid;
    t_item             r_item;
    t_item             n_item;
    logic [WIDE_W-1:0] ext;
    logic [WIDE_W-1:0] sub;
    logic [3:0]        d;

    assign o_ready = !r_valid || i_ready_dn;

    always_comb begin
        ext = {{(WIDE_W-VALUE_W){1'b0}}, i_item.rem};
        d   = '0;
        sub = '0;
        for (int m = 1; m < 10; m++) begin
            if (ext >= WIDE_W'(WIDE_W'(m) * P)) begin
                d   = 4'(m);
                sub = WIDE_W'(WIDE_W'(m) * P);
            end
        end
        n_item           = i_item;
        n_item.digits[K] = d;
        n_item.rem       = VALUE_W'(ext - sub);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### design/rdf_serializer.sv
// ----------------------------------------------------------------------------
// rdf_serializer
// Walks the digit positions from the top, drops leading zeros unless padding
// is asked for, and drives the registered character output.
// ----------------------------------------------------------------------------
module rdf_serializer import rdf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_item       i_item,
    output logic        o_ready,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [6:0]  o_char,
    output logic        o_m_tlast
);

    logic             r_busy;
    logic [POS_W-1:0] r_pos;
    logic             r_sending;
    t_item            r_item;
    logic             r_ovalid;
    logic [6:0]       r_char;
    logic             r_last;

    logic [VALUE_W+2:0] vext;
    logic [5:0]         shamt;
    logic [VALUE_W+2:0] shifted;
    logic [3:0]         d;
    logic               emit;
    logic               slot_free;
    logic               fire;

    assign o_ready   = !r_busy;
    assign slot_free = !r_ovalid || i_m_tready;

    always_comb begin
        vext  = {3'b000, r_item.value};
        shamt = '0;
        case (r_item.radix)
            RADIX_BIN: shamt = 6'(r_pos);
            RADIX_OCT: shamt = 6'({r_pos, 1'b0}) + 6'(r_pos);
            RADIX_HEX: shamt = 6'({r_pos, 2'b00});
            default:   shamt = '0;
        endcase
        shifted = vext >> shamt;
        case (r_item.radix)
            RADIX_BIN: d = {3'b000, shifted[0]};
            RADIX_OCT: d = {1'b0, shifted[2:0]};
            RADIX_HEX: d = shifted[3:0];
            default:   d = r_item.digits[r_pos[3:0]];
        endcase
        emit = r_sending || (d != 4'd0) || (r_pos == '0);
        fire = r_busy && emit && slot_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_sending <= 1'b0;
            r_ovalid  <= 1'b0;
            r_pos     <= '0;
        end else begin
            if (!r_busy) begin
                if (i_valid) begin
                    r_busy    <= 1'b1;
                    r_sending <= i_item.pad;
                    r_pos     <= POS_W'(i_item.ndig - CNT_W'(1));
                end
            end else if (!emit) begin
                r_pos <= r_pos - POS_W'(1);
            end else if (slot_free) begin
                r_sending <= 1'b1;
                if (r_pos == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_pos <= r_pos - POS_W'(1);
                end
            end

            if (fire) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy && i_valid) begin
            r_item <= i_item;
        end
        if (fire) begin
            r_char <= to_ascii(d);
            r_last <= (r_pos == '0);
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_char     = r_char;
    assign o_m_tlast  = r_last;

endmodule

### design/rdf_checker.sv
// ----------------------------------------------------------------------------
// rdf_checker
// Port-level checks for the radix digit formatter.
// ----------------------------------------------------------------------------
module rdf_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        o_s_tready,
    input  logic        o_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  o_m_tdata,
    input  logic        o_m_tlast
);

    // Output request holds while stalled.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast)))
        else $error("output request dropped or changed under stall");

    // Only digit characters leave the block.
    a_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |->
            ((o_m_tdata >= 8'd48 && o_m_tdata <= 8'd57) ||
             (o_m_tdata >= 8'd65 && o_m_tdata <= 8'd70)))
        else $error("non-digit character on output");

    // Reset empties the output register.
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // A request taken right after reset does not reach the output in the cycle after it.
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(o_m_tvalid) && !o_m_tvalid && i_s_tvalid && o_s_tready
            && $past(!i_rst_n)) |=> !o_m_tvalid)
        else $error("output appeared without pipeline latency");

endmodule

bind radix_digit_formatter_top rdf_checker u_rdf_checker (.*);

### verif/radix_digit_formatter_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_formatter_top_tb
// Self-checking bench for the radix digit formatter. Numbers go in as stream
// requests; a local model works out the ASCII digit string for each accepted
// request and the output side checks every character and its last flag in
// order. Covers directed corner values, a long output hold-off, a sender
// pause and a long randomized run with gaps on both sides switched on and off.
// ----------------------------------------------------------------------------
module radix_digit_formatter_top_tb;
    import rdf_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int TAIL_CYCLES = 60;
    localparam logic [6:0] CHAR_ZERO = 7'h30;          // '0'
    localparam logic [6:0] CHAR_LETTER_BASE = 7'h37;   // 'A' - 10

    typedef struct packed {
        logic [6:0] ascii_char;
        logic       last_char;
    } t_digit_char;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;    // [31:0] value
    logic [4:0]  s_tuser = '0;    // [1:0] size_code, [3:2] radix_code, [4] pad_zeros
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // [6:0] ascii_char, [7] zero
    logic        m_tlast;         // last_char

    t_digit_char expected_digits[$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          hold_request = 0;
    bit          sender_gaps = 1'b0;
    bit          receiver_stalls = 1'b0;

    radix_digit_formatter_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Queues the digit string for one number, MSB first.
    function automatic void predict_digits(input logic [31:0] value, input t_size sz,
                                           input t_radix rc, input logic pad);
        logic [31:0] rem;
        int unsigned base;
        int          ndig;
        int          size_idx;
        logic [3:0]  dig [32];
        bit          emitting;
        t_digit_char c;
        size_idx = (sz == SIZE_BYTE) ? 0 : (sz == SIZE_WORD) ? 1 : 2;
        case (size_idx)
            0:       rem = {24'h0, value[7:0]};
            1:       rem = {16'h0, value[15:0]};
            default: rem = value;
        endcase
        case (rc)
            RADIX_BIN: begin
                base = 2;
                ndig = 8 << size_idx;
            end
            RADIX_OCT: begin
                base = 8;
                ndig = (size_idx == 0) ? 3 : (size_idx == 1) ? 6 : 11;
            end
            RADIX_DEC: begin
                base = 10;
                ndig = (size_idx == 0) ? 3 : (size_idx == 1) ? 5 : 10;
            end
            default: begin
                base = 16;
                ndig = 2 << size_idx;
            end
        endcase
        for (int i = 0; i < ndig; i++) begin
            dig[i] = 4'(rem % base);
            rem = rem / base;
        end
        emitting = pad;
        for (int i = ndig - 1; i >= 0; i--) begin
            // first nonzero digit (or the units digit) opens the string
            if (dig[i] != 4'd0 || i == 0) emitting = 1'b1;
            if (emitting) begin
                c.ascii_char = (dig[i] < 4'd10) ? CHAR_ZERO + 7'(dig[i])
                                                : CHAR_LETTER_BASE + 7'(dig[i]);
                c.last_char = (i == 0);
                expected_digits.push_back(c);
            end
        end
    endfunction

    function automatic logic [31:0] random_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom();
            4:          return $urandom_range(0, 20);
            5:          return $urandom_range(0, 255);
            6:          return $urandom_range(0, 65535);
            7:          return 32'hFFFF_FFFF;
            8:          return 32'h1 << $urandom_range(0, 31);
            default:    return 32'h0;
        endcase
    endfunction

    // Leaves tvalid high on return so a back-to-back request needs no toggle.
    task automatic send_number(input logic [31:0] value, input t_size sz,
                               input t_radix rc, input logic pad);
        int gap;
        gap = (sender_gaps && $urandom_range(0, 99) < 30) ? gap_length() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= {pad, rc, sz};
        @(posedge clk);
        while (s_tready !== 1'b1) @(posedge clk);
        predict_digits(value, sz, rc, pad);
    endtask

    task automatic send_random_number();
        send_number(random_value(), t_size'($urandom_range(0, 3)),
                    t_radix'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    endtask

    task automatic wait_for_digits();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (expected_digits.size() != 0);
    endtask

    // Output side: check each accepted character, then pick the next ready.
    initial begin
        int          stall_left;
        int          hold_left;
        t_digit_char want;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge clk);
            if (rst_n && m_tvalid === 1'b1 && m_tready) begin
                if (expected_digits.size() == 0) begin
                    $error("unexpected character: tdata %h tlast %b", m_tdata, m_tlast);
                    error_count++;
                end else begin
                    want = expected_digits.pop_front();
                    if (m_tdata[6:0] !== want.ascii_char) begin
                        $error("ascii_char: expected %h, actual %h",
                               want.ascii_char, m_tdata[6:0]);
                        error_count++;
                    end
                    if (m_tlast !== want.last_char) begin
                        $error("last_char: expected %b, actual %b", want.last_char, m_tlast);
                        error_count++;
                    end
                    if (m_tdata[7] !== 1'b0) begin
                        $error("tdata[7]: expected 0, actual %b", m_tdata[7]);
                        error_count++;
                    end
                end
            end
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (receiver_stalls && $urandom_range(0, 99) < 25) begin
                stall_left = gap_length() - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    task automatic test_directed_cases();
        sender_gaps = 1'b1;
        receiver_stalls = 1'b1;
        // all-zero value without padding gives a lone '0'
        send_number(32'h0, SIZE_LONG, RADIX_BIN, 1'b0);
        send_number(32'h0, SIZE_LONG, RADIX_OCT, 1'b0);
        send_number(32'h0, SIZE_LONG, RADIX_DEC, 1'b0);
        send_number(32'h0, SIZE_LONG, RADIX_HEX, 1'b0);
        send_number(32'h0, SIZE_BYTE, RADIX_HEX, 1'b1);
        send_number(32'hFFFF_FFFF, SIZE_LONG, RADIX_BIN, 1'b0);
        send_number(32'hFFFF_FFFF, SIZE_LONG, RADIX_OCT, 1'b0);
        send_number(32'hFFFF_FFFF, SIZE_LONG, RADIX_DEC, 1'b0);
        send_number(32'hFFFF_FFFF, SIZE_LONG, RADIX_HEX, 1'b0);
        // mask keeps the top digit within the radix
        send_number(32'h0000_01FF, SIZE_BYTE, RADIX_DEC, 1'b0);
        send_number(32'hFFFF_FFFF, SIZE_BYTE, RADIX_OCT, 1'b0);
        send_number(32'h1234_0000, SIZE_WORD, RADIX_DEC, 1'b0);
        send_number(32'd7, SIZE_WORD, RADIX_DEC, 1'b1);
        // size code three behaves as long
        send_number(32'hDEAD_BEEF, SIZE_ALT_LONG, RADIX_HEX, 1'b0);
        send_number(32'h8000_0001, SIZE_ALT_LONG, RADIX_BIN, 1'b0);
        send_number(32'hABCD_EF01, SIZE_LONG, RADIX_HEX, 1'b0);
        send_number(32'h8000_0000, SIZE_LONG, RADIX_OCT, 1'b0);
        send_number(32'd5, SIZE_BYTE, RADIX_BIN, 1'b1);
        send_number(32'd1_000_000_000, SIZE_LONG, RADIX_DEC, 1'b0);
        send_number(32'h0000_FFFF, SIZE_WORD, RADIX_OCT, 1'b1);
        send_number(32'h0000_00A5, SIZE_BYTE, RADIX_HEX, 1'b0);
        send_number(32'h1, SIZE_LONG, RADIX_BIN, 1'b1);
        wait_for_digits();
    endtask

    // Output held off long enough for the pipeline to fill and stall requests.
    task automatic test_output_backpressure();
        sender_gaps = 1'b0;
        receiver_stalls = 1'b0;
        hold_request = 300;
        repeat (24) send_random_number();
        wait_for_digits();
    endtask

    task automatic test_sender_pause();
        sender_gaps = 1'b1;
        receiver_stalls = 1'b1;
        repeat (10) send_random_number();
        wait_for_digits();
        repeat (10) send_random_number();
        wait_for_digits();
    endtask

    task automatic test_random_numbers();
        for (int chunk = 0; chunk < 9; chunk++) begin
            case (chunk)
                0: begin
                    sender_gaps = 1'b0;
                    receiver_stalls = 1'b0;
                end
                1: begin
                    sender_gaps = 1'b1;
                    receiver_stalls = 1'b1;
                end
                default: begin
                    sender_gaps = 1'($urandom_range(0, 1));
                    receiver_stalls = 1'($urandom_range(0, 1));
                end
            endcase
            repeat (35) send_random_number();
        end
        wait_for_digits();
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_output_backpressure();
        test_sender_pause();
        test_random_numbers();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
